/* src/sts_pkg.sv */
// Shared types, sizes and codes for the sum-tree prioritized sampler.
package sts_pkg;

    localparam int CAPACITY    = 1024;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 64;
    localparam int WEIGHT_BITS = 32;
    localparam int FRAC_W      = 32;
    localparam int SUM_W       = 42;
    localparam int HI_W        = SUM_W - FRAC_W;
    localparam int FUNC_W      = 3;
    localparam int STAT_W      = 3;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [KEY_W-1:0]       item_key;
        logic [WEIGHT_BITS-1:0] item_weight;
        logic [FRAC_W-1:0]      random_fraction;
    } sts_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic [KEY_W-1:0]       sampled_key;
        logic [WEIGHT_BITS-1:0] chosen_weight;
        logic [SUM_W-1:0]       root_total;
    } sts_out_t;

endpackage

/* src/sum_tree_prioritized_sampler_unit.sv */
// Top level: sum-tree prioritized sampler with a sequenced walk over three RAMs.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_data (sts_in_t)
//  m_      | out | m_valid / m_ready  | m_data (sts_out_t)
//
// One item at a time; s_ready is high only in the idle state.
// Key lookup scans the key RAM one slot per cycle.
// Each tree level then takes a sum RAM read-modify-write (update,
// insert; delete walks two paths) or a descent step (sample).
// Clear only zeroes the entry count; slots at or above the entry count
// read as zero, so no clearing pass is needed after reset. A stalled
// m_ready holds the result and delays only the return to idle.
module sum_tree_prioritized_sampler_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sts_pkg::sts_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sts_pkg::sts_out_t m_data
);
    import sts_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SRCH    = 5'd1;
    localparam logic [4:0] S_DECIDE  = 5'd2;
    localparam logic [4:0] S_UPD_WT  = 5'd3;
    localparam logic [4:0] S_DEL_RD2 = 5'd4;
    localparam logic [4:0] S_DEL_RD3 = 5'd5;
    localparam logic [4:0] S_WALK_RD = 5'd6;
    localparam logic [4:0] S_WALK_WR = 5'd7;
    localparam logic [4:0] S_SMP_RD0 = 5'd8;
    localparam logic [4:0] S_SMP_TOT = 5'd9;
    localparam logic [4:0] S_UNI_KEY = 5'd10;
    localparam logic [4:0] S_SMP_MUL = 5'd11;
    localparam logic [4:0] S_SMP_TGT = 5'd12;
    localparam logic [4:0] S_DESC_L  = 5'd13;
    localparam logic [4:0] S_DESC_LC = 5'd14;
    localparam logic [4:0] S_DESC_RC = 5'd15;
    localparam logic [4:0] S_PICK    = 5'd16;
    localparam logic [4:0] S_PICK_WT = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;

    logic [4:0]             state_reg, state_next;
    logic [FUNC_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [WEIGHT_BITS-1:0] wt_reg, wt_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   pend_reg, pend_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [IDX_W-1:0]       walk_idx_reg, walk_idx_next;
    logic [SUM_W-1:0]       delta_reg, delta_next;
    logic                   second_reg, second_next;
    logic [WEIGHT_BITS-1:0] wl_reg, wl_next;
    logic [KEY_W-1:0]       kl_reg, kl_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic [2*FRAC_W-1:0]    plo_reg, plo_next;
    logic [SUM_W-1:0]       target_reg, target_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    sts_out_t               res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    sts_out_t               m_data_reg, m_data_next;

    logic                   key_we, wt_we, sum_we;
    logic [IDX_W-1:0]       key_waddr, wt_waddr, sum_waddr;
    logic [IDX_W-1:0]       key_raddr, wt_raddr, sum_raddr;
    logic [KEY_W-1:0]       key_wdata, key_rdata;
    logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata;
    logic [SUM_W-1:0]       sum_wdata, sum_rdata;

    sts_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );
    sts_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CAPACITY)) u_wt_ram (
        .aclk(aclk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );
    sts_ram #(.WIDTH(SUM_W), .DEPTH(CAPACITY)) u_sum_ram (
        .aclk(aclk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    // helpers
    logic [CNT_W-1:0]          last_full;
    logic [IDX_W-1:0]          last_idx;
    logic [IDX_W-1:0]          walk_dec;
    logic [IDX_W-1:0]          parent_idx;
    logic                      walk_live;
    logic [SUM_W-1:0]          walk_sum;
    logic [CNT_W:0]            lchild, rchild;
    logic                      l_live, r_live;
    logic [SUM_W-1:0]          ls_val, rs_val;
    logic [FRAC_W+CNT_W-1:0]   uni_prod;
    logic [IDX_W-1:0]          uni_pos;
    logic [2*FRAC_W-1:0]       lo_prod;
    logic [SUM_W-1:0]          hi_prod;
    logic                      hit;

    assign last_full  = count_reg - CNT_W'(1);
    assign last_idx   = last_full[IDX_W-1:0];
    assign walk_dec   = walk_idx_reg - IDX_W'(1);
    assign parent_idx = {1'b0, walk_dec[IDX_W-1:1]};
    assign walk_live  = {1'b0, walk_idx_reg} < count_reg;
    assign walk_sum   = (walk_live ? sum_rdata : '0) + delta_reg;
    assign lchild     = {1'b0, idx_reg, 1'b1};
    assign rchild     = {1'b0, idx_reg, 1'b0} + (CNT_W+1)'(2);
    assign l_live     = lchild < {1'b0, count_reg};
    assign r_live     = rchild < {1'b0, count_reg};
    assign ls_val     = l_live ? sum_rdata : '0;
    assign rs_val     = r_live ? sum_rdata : '0;
    assign uni_prod   = {{CNT_W{1'b0}}, frac_reg} * {{FRAC_W{1'b0}}, count_reg};
    assign uni_pos    = uni_prod[FRAC_W+IDX_W-1:FRAC_W];
    assign lo_prod    = {{FRAC_W{1'b0}}, frac_reg} * {{FRAC_W{1'b0}}, total_reg[FRAC_W-1:0]};
    assign hi_prod    = {{HI_W{1'b0}}, frac_reg} * {{FRAC_W{1'b0}}, total_reg[SUM_W-1:FRAC_W]};
    assign hit        = pend_reg && (key_rdata == key_reg);

    function automatic logic [IDX_W-1:0] last_scan(input logic [CNT_W-1:0] scan);
        logic [CNT_W-1:0] prev;
        prev = scan - CNT_W'(1);
        return prev[IDX_W-1:0];
    endfunction

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        wt_next       = wt_reg;
        frac_next     = frac_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        walk_idx_next = walk_idx_reg;
        delta_next    = delta_reg;
        second_next   = second_reg;
        wl_next       = wl_reg;
        kl_next       = kl_reg;
        total_next    = total_reg;
        plo_next      = plo_reg;
        target_next   = target_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        key_we    = 1'b0;
        key_waddr = '0;
        key_wdata = key_reg;
        key_raddr = '0;
        wt_we     = 1'b0;
        wt_waddr  = slot_reg;
        wt_wdata  = wt_reg;
        wt_raddr  = '0;
        sum_we    = 1'b0;
        sum_waddr = walk_idx_reg;
        sum_wdata = walk_sum;
        sum_raddr = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_data.func;
                    key_next  = s_data.item_key;
                    wt_next   = s_data.item_weight;
                    frac_next = s_data.random_fraction;
                    res_next  = '0;
                    scan_next = '0;
                    pend_next = 1'b0;
                    case (s_data.func)
                        FUNC_INSERT, FUNC_UPDATE, FUNC_DELETE: begin
                            state_next = S_SRCH;
                        end
                        FUNC_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                                state_next      = S_OUT;
                            end else begin
                                state_next = S_SMP_RD0;
                            end
                        end
                        FUNC_CLEAR: begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // one key read issued per cycle, compared in the next cycle
                key_raddr = scan_reg[IDX_W-1:0];
                if (hit) begin
                    found_next = 1'b1;
                    slot_next  = last_scan(scan_reg);
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end else if (scan_reg < count_reg) begin
                    scan_next = scan_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (op_reg)
                    FUNC_INSERT: begin
                        if (found_reg) begin
                            res_next.status = STAT_DUP;
                            state_next      = S_OUT;
                        end else if (count_reg == CNT_W'(CAPACITY)) begin
                            res_next.status = STAT_FULL;
                            state_next      = S_OUT;
                        end else begin
                            key_we        = 1'b1;
                            key_waddr     = count_reg[IDX_W-1:0];
                            wt_we         = 1'b1;
                            wt_waddr      = count_reg[IDX_W-1:0];
                            delta_next    = {{HI_W{1'b0}}, wt_reg};
                            walk_idx_next = count_reg[IDX_W-1:0];
                            second_next   = 1'b0;
                            state_next    = S_WALK_RD;
                        end
                    end
                    FUNC_UPDATE: begin
                        if (!found_reg) begin
                            res_next.status = STAT_NOTFOUND;
                            state_next      = S_OUT;
                        end else begin
                            wt_raddr   = slot_reg;
                            state_next = S_UPD_WT;
                        end
                    end
                    FUNC_DELETE: begin
                        if (!found_reg) begin
                            res_next.status = STAT_NOTFOUND;
                            state_next      = S_OUT;
                        end else begin
                            wt_raddr   = last_idx;
                            key_raddr  = last_idx;
                            state_next = S_DEL_RD2;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_UPD_WT: begin
                delta_next    = {{HI_W{1'b0}}, wt_reg} - {{HI_W{1'b0}}, wt_rdata};
                wt_we         = 1'b1;
                walk_idx_next = slot_reg;
                second_next   = 1'b0;
                state_next    = S_WALK_RD;
            end
            S_DEL_RD2: begin
                wl_next    = wt_rdata;
                kl_next    = key_rdata;
                wt_raddr   = slot_reg;
                state_next = S_DEL_RD3;
            end
            S_DEL_RD3: begin
                // last slot moves into the hole, then its old path loses wl
                delta_next    = {{HI_W{1'b0}}, wl_reg} - {{HI_W{1'b0}}, wt_rdata};
                wt_we         = 1'b1;
                wt_wdata      = wl_reg;
                key_we        = 1'b1;
                key_waddr     = slot_reg;
                key_wdata     = kl_reg;
                walk_idx_next = slot_reg;
                second_next   = 1'b1;
                state_next    = S_WALK_RD;
            end
            S_WALK_RD: begin
                sum_raddr  = walk_idx_reg;
                state_next = S_WALK_WR;
            end
            S_WALK_WR: begin
                sum_we = 1'b1;
                if (walk_idx_reg == '0) begin
                    if (second_reg) begin
                        second_next   = 1'b0;
                        walk_idx_next = last_idx;
                        delta_next    = '0 - {{HI_W{1'b0}}, wl_reg};
                        state_next    = S_WALK_RD;
                    end else begin
                        if (op_reg == FUNC_INSERT) begin
                            count_next = count_reg + CNT_W'(1);
                        end else if (op_reg == FUNC_DELETE) begin
                            count_next = last_full;
                        end
                        state_next = S_OUT;
                    end
                end else begin
                    walk_idx_next = parent_idx;
                    state_next    = S_WALK_RD;
                end
            end
            S_SMP_RD0: begin
                sum_raddr  = '0;
                state_next = S_SMP_TOT;
            end
            S_SMP_TOT: begin
                total_next = sum_rdata;
                if (sum_rdata == '0) begin
                    key_raddr              = uni_pos;
                    res_next.chosen_weight = WEIGHT_BITS'(1);
                    res_next.root_total    = SUM_W'(count_reg);
                    state_next             = S_UNI_KEY;
                end else begin
                    state_next = S_SMP_MUL;
                end
            end
            S_UNI_KEY: begin
                res_next.sampled_key = key_rdata;
                state_next           = S_OUT;
            end
            S_SMP_MUL: begin
                plo_next   = lo_prod;
                state_next = S_SMP_TGT;
            end
            S_SMP_TGT: begin
                target_next = hi_prod + {{HI_W{1'b0}}, plo_reg[2*FRAC_W-1:FRAC_W]};
                idx_next    = '0;
                state_next  = S_DESC_L;
            end
            S_DESC_L: begin
                sum_raddr  = lchild[IDX_W-1:0];
                state_next = S_DESC_LC;
            end
            S_DESC_LC: begin
                if (target_reg < ls_val) begin
                    idx_next   = lchild[IDX_W-1:0];
                    state_next = S_DESC_L;
                end else begin
                    target_next = target_reg - ls_val;
                    sum_raddr   = rchild[IDX_W-1:0];
                    state_next  = S_DESC_RC;
                end
            end
            S_DESC_RC: begin
                if (target_reg < rs_val) begin
                    idx_next   = rchild[IDX_W-1:0];
                    state_next = S_DESC_L;
                end else begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                key_raddr  = idx_reg;
                wt_raddr   = idx_reg;
                state_next = S_PICK_WT;
            end
            S_PICK_WT: begin
                res_next.sampled_key   = key_rdata;
                res_next.chosen_weight = wt_rdata;
                res_next.root_total    = total_reg;
                state_next             = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        wt_reg       <= wt_next;
        frac_reg     <= frac_next;
        scan_reg     <= scan_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        walk_idx_reg <= walk_idx_next;
        delta_reg    <= delta_next;
        wl_reg       <= wl_next;
        kl_reg       <= kl_next;
        total_reg    <= total_next;
        plo_reg      <= plo_next;
        target_reg   <= target_next;
        idx_reg      <= idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

/* src/sts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/sts_checker.sv */
// Port-level checker for the sampler, bound to the top level.
module sts_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input sts_pkg::sts_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input sts_pkg::sts_out_t m_data
);
    import sts_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |->
            m_data.sampled_key == '0 && m_data.chosen_weight == '0 &&
            m_data.root_total == '0)
        else $error("error result carries data");

    a_pick_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> SUM_W'(m_data.chosen_weight) <= m_data.root_total)
        else $error("picked weight above total");
endmodule

bind sum_tree_prioritized_sampler_unit sts_checker u_sts_checker (.*);

/* dv/tb_sum_tree_prioritized_sampler_unit.sv */
// Testbench for the sum-tree sampler: directed and random items checked against a local model.
module tb_sum_tree_prioritized_sampler_unit;
    import sts_pkg::*;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sts_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sts_out_t m_data;

    sum_tree_prioritized_sampler_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // shadow copy of the store
    logic [KEY_W-1:0]       key_mem [CAPACITY];
    logic [WEIGHT_BITS-1:0] wt_mem  [CAPACITY];
    logic [SUM_W-1:0]       sum_mem [CAPACITY];
    int unsigned            n_entries;

    sts_in_t  pending_items [$];
    sts_out_t expected_results [$];
    int       n_errors;
    int       n_checked;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       recv_hold;
    int       hold_cycles;
    int       n_sampled;
    int       n_uniform;
    logic [KEY_W-1:0] live_keys [$];

    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < n_entries; i++)
            if (key_mem[i] == k) return i;
        return -1;
    endfunction

    function automatic void set_weight(int slot, logic [WEIGHT_BITS-1:0] w);
        logic [SUM_W-1:0] delta;
        delta = SUM_W'(w) - SUM_W'(wt_mem[slot]);
        wt_mem[slot] = w;
        forever begin
            sum_mem[slot] = sum_mem[slot] + delta;
            if (slot == 0) break;
            slot = (slot - 1) / 2;
        end
    endfunction

    function automatic logic [SUM_W-1:0] sum_of(int slot);
        return (slot < n_entries) ? sum_mem[slot] : '0;
    endfunction

    function automatic sts_out_t apply_op(sts_in_t it);
        sts_out_t r;
        int slot;
        int last;
        logic [63:0] tot, target, pos, ls, rs;
        int idx;
        r = '0;
        r.status = STAT_OK;
        slot = find_key(it.item_key);
        case (it.func)
            FUNC_INSERT: begin
                if (slot >= 0) r.status = STAT_DUP;
                else if (n_entries >= CAPACITY) r.status = STAT_FULL;
                else begin
                    key_mem[n_entries] = it.item_key;
                    set_weight(n_entries, it.item_weight);
                    n_entries++;
                end
            end
            FUNC_UPDATE: begin
                if (slot >= 0) set_weight(slot, it.item_weight);
                else r.status = STAT_NOTFOUND;
            end
            FUNC_DELETE: begin
                if (slot < 0) r.status = STAT_NOTFOUND;
                else begin
                    last = n_entries - 1;
                    if (slot != last) begin
                        set_weight(slot, wt_mem[last]);
                        key_mem[slot] = key_mem[last];
                    end
                    set_weight(last, '0);
                    n_entries = last;
                end
            end
            FUNC_SAMPLE: begin
                if (n_entries == 0) r.status = STAT_EMPTY;
                else begin
                    tot = 64'(sum_mem[0]);
                    if (tot == 0) begin
                        pos = (64'(it.random_fraction) * 64'(n_entries)) >> 32;
                        if (pos >= n_entries) pos = n_entries - 1;
                        r.sampled_key = key_mem[pos];
                        r.chosen_weight = 1;
                        r.root_total = SUM_W'(n_entries);
                        n_uniform++;
                    end else begin
                        target = 64'(it.random_fraction) * (tot >> 32)
                               + ((64'(it.random_fraction) * {32'd0, tot[31:0]}) >> 32);
                        idx = 0;
                        forever begin
                            ls = 64'(sum_of(2 * idx + 1));
                            if (target < ls) begin
                                idx = 2 * idx + 1;
                                continue;
                            end
                            target = target - ls;
                            rs = 64'(sum_of(2 * idx + 2));
                            if (target < rs) begin
                                idx = 2 * idx + 2;
                                continue;
                            end
                            break;
                        end
                        r.sampled_key = key_mem[idx];
                        r.chosen_weight = wt_mem[idx];
                        r.root_total = SUM_W'(tot);
                    end
                    n_sampled++;
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    wt_mem[i] = '0;
                    sum_mem[i] = '0;
                end
                n_entries = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // builds one item; live_keys holds keys likely to be present, to aim updates and deletes
    function automatic sts_in_t make_item(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                          logic [WEIGHT_BITS-1:0] w, logic [FRAC_W-1:0] fr);
        sts_in_t it;
        it.func = f;
        it.item_key = k;
        it.item_weight = w;
        it.random_fraction = fr;
        return it;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if (live_keys.size() > 0 && $urandom_range(0, 9) < 8)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic sts_in_t rand_item(int max_fill);
        logic [KEY_W-1:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35 && live_keys.size() < max_fill) begin
            k = (live_keys.size() > 0 && $urandom_range(0, 9) == 0)
                ? live_keys[0] : {$urandom, $urandom};
            live_keys.push_back(k);
            return make_item(FUNC_INSERT, k, rand_weight(), $urandom);
        end
        if (sel < 50) return make_item(FUNC_UPDATE, pick_key(), rand_weight(), $urandom);
        if (sel < 62) begin
            k = pick_key();
            foreach (live_keys[i]) if (live_keys[i] == k) begin
                live_keys.delete(i);
                break;
            end
            return make_item(FUNC_DELETE, k, rand_weight(), $urandom);
        end
        if (sel < 97) return make_item(FUNC_SAMPLE, {$urandom, $urandom}, $urandom, $urandom);
        if (sel < 98) begin
            live_keys.delete();
            return make_item(FUNC_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
        end
        return make_item(FUNC_W'($urandom_range(5, 7)), pick_key(), $urandom, $urandom);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // prediction on acceptance, monitor on result
    always @(posedge aclk) begin
        sts_out_t exp_r;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_op(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    n_checked++;
                    if (m_data.status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                                 m_data.status);
                        n_errors++;
                    end
                    if (m_data.sampled_key !== exp_r.sampled_key) begin
                        $display("%0t: sampled_key exp %h got %h", $time,
                                 exp_r.sampled_key, m_data.sampled_key);
                        n_errors++;
                    end
                    if (m_data.chosen_weight !== exp_r.chosen_weight) begin
                        $display("%0t: chosen_weight exp %h got %h", $time,
                                 exp_r.chosen_weight, m_data.chosen_weight);
                        n_errors++;
                    end
                    if (m_data.root_total !== exp_r.root_total) begin
                        $display("%0t: root_total exp %h got %h", $time,
                                 exp_r.root_total, m_data.root_total);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (recv_hold) begin
            hold_cycles <= 300;
            m_ready <= 1'b0;
        end else m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // sampled away from the rising edge so that the clocked processes have settled
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
    endtask

    initial begin
        n_errors = 0; n_checked = 0; n_sampled = 0; n_uniform = 0;
        n_entries = 0; recv_hold = 0;
        send_idle_pct = 18; recv_idle_pct = 50;
        for (int i = 0; i < CAPACITY; i++) begin
            key_mem[i] = '0; wt_mem[i] = '0; sum_mem[i] = '0;
        end
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, uniform case, extremes, error codes
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '1));
        pending_items.push_back(make_item(FUNC_DELETE, '1, '0, '0));
        pending_items.push_back(make_item(FUNC_UPDATE, '1, '1, '0));
        pending_items.push_back(make_item(FUNC_INSERT, '1, '0, '0));
        pending_items.push_back(make_item(FUNC_INSERT, '0, '0, '0));
        pending_items.push_back(make_item(FUNC_INSERT, 64'h5555_aaaa_5555_aaaa, '0, '0));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '0));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '1));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, 32'h8000_0000));
        pending_items.push_back(make_item(FUNC_INSERT, '1, '0, '0));
        pending_items.push_back(make_item(FUNC_UPDATE, '1, '1, '0));
        pending_items.push_back(make_item(FUNC_INSERT, 64'haaaa_5555_aaaa_5555, '1, '1));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '0));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '1));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, 32'h7fff_ffff));
        pending_items.push_back(make_item(FUNC_DELETE, '0, '0, '0));
        pending_items.push_back(make_item(FUNC_SAMPLE, '1, '1, 32'h8000_0000));
        pending_items.push_back(make_item(3'd5, '1, '1, '1));
        pending_items.push_back(make_item(3'd7, '0, '0, '0));
        pending_items.push_back(make_item(FUNC_CLEAR, '1, '1, '1));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '0));
        drain();

        // fill to capacity: full-store and duplicate checks, deep tree
        for (int i = 0; i < CAPACITY; i++)
            pending_items.push_back(make_item(FUNC_INSERT, 64'(i) << 20 | 64'h3,
                                              (i % 7 == 0) ? '0 : rand_weight(), '0));
        pending_items.push_back(make_item(FUNC_INSERT, 64'h1234, '1, '0));
        pending_items.push_back(make_item(FUNC_INSERT, 64'h3, '1, '0));
        for (int i = 0; i < 20; i++)
            pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, $urandom));
        pending_items.push_back(make_item(FUNC_DELETE, 64'h3, '0, '0));
        pending_items.push_back(make_item(FUNC_SAMPLE, '0, '0, '1));
        pending_items.push_back(make_item(FUNC_CLEAR, '0, '0, '0));
        drain();

        // random, first phase with a long receiver hold-off
        for (int i = 0; i < 30; i++) pending_items.push_back(rand_item(40));
        recv_hold = 1;
        repeat (2) @(posedge aclk);
        recv_hold = 0;
        drain();
        send_idle_pct = 50; recv_idle_pct = 18;
        for (int i = 0; i < 30; i++) pending_items.push_back(rand_item(40));
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 30; i++) pending_items.push_back(rand_item(40));
        drain();
        repeat (50) @(posedge aclk);

        $display("Checked %0d results; %0d samples, %0d by uniform pick.",
                 n_checked, n_sampled, n_uniform);
        if (n_errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #60000000;
        $display("Verification failed");
        $finish;
    end
endmodule

/* files.f */
src/sts_pkg.sv
src/sts_ram.sv
src/sum_tree_prioritized_sampler_unit.sv
src/sts_checker.sv
dv/tb_sum_tree_prioritized_sampler_unit.sv
